@@ hw/rtl/pip_pkg.sv @@
package pip_pkg;

  // Width of the vertex count register
  localparam int CountWidth = 7;

  // Function codes of an input transaction
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Query sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/point_in_polygon_test.sv @@
// Vertex load: accepted while idle, gives no result, and the block stays ready.
// Query: RUN reads the n = min(vertex_count, MAX_VERTICES) edges, then DRAIN and DONE, or
// DONE at once with no vertices; in_ready returns in the same cycle as the result.
// The memory's single read port feeds one edge per cycle into a subtract, multiply,
// compare pipeline; a result still waiting on out_ready holds the block in its last step.
// Reset (rst, synchronous, active high) clears vertex_count and all control state;
// vertex memory contents are not cleared and must be written before use.
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [$clog2(MAX_VERTICES)-1:0] vertex_index,
  input  logic signed [COORD_WIDTH-1:0]   coord_x,
  input  logic signed [COORD_WIDTH-1:0]   coord_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            inside_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CountWidth-1:0]           vertex_count
);

  localparam int IdxW = $clog2(MAX_VERTICES);
  localparam int CntW = $clog2(MAX_VERTICES + 1);
  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int FW   = PW + 1;

  state_t state, state_next;

  logic [CountWidth-1:0] vcount;
  logic [CntW-1:0]       n_eff, n_q, k, rd_addr_full;
  logic [IdxW-1:0]       rd_addr;
  logic                  rd_en, fin, parity, res_valid, res;
  logic                  q_accept, ld_accept;

  logic signed [COORD_WIDTH-1:0] px, py;

  // Vertex memory: {x, y} per entry
  logic [2*COORD_WIDTH-1:0] mem [MAX_VERTICES];
  logic [2*COORD_WIDTH-1:0] rd_data;
  logic                     rd_vld, rd_first;

  // Edge pipeline
  logic signed [COORD_WIDTH-1:0] xi, yi, prev_x, prev_y;
  logic signed [DW-1:0]          ax, dy, bx, by;
  logic                          e_vld, e_str, e_dypos;
  logic signed [PW-1:0]          p1, p2;
  logic                          m_vld, m_str, m_dypos;
  logic signed [FW-1:0]          diff;
  logic                          left;

  assign cfg_ready  = 1'b1;
  assign out_valid  = res_valid;
  assign inside_res = res;

  assign q_accept  = in_valid && in_ready && (func == FUNC_QUERY);
  assign ld_accept = in_valid && in_ready && (func == FUNC_LOAD);

  // Saturate the count at the table capacity
  always_comb begin
    if (32'(vcount) > MAX_VERTICES) begin
      n_eff = CntW'(MAX_VERTICES);
    end else begin
      n_eff = CntW'(vcount);
    end
  end

  // Read order: last vertex first, then 0 .. n-1
  assign rd_addr_full = (k == '0) ? (n_q - 1'b1) : (k - 1'b1);
  assign rd_addr      = rd_addr_full[IdxW-1:0];

  // Hold the count register
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
    end else if (cfg_valid) begin
      vcount <= vertex_count;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer controls
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    fin        = 1'b0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && func == FUNC_QUERY) begin
          state_next = (n_eff == '0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        rd_en = 1'b1;
        if (k == n_q) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(rd_vld || e_vld || m_vld)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || out_ready) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Capture the query point and advance the read counter
  always_ff @(posedge clk) begin
    if (q_accept) begin
      px  <= coord_x;
      py  <= coord_y;
      n_q <= n_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (q_accept) begin
      k <= '0;
    end else if (rd_en) begin
      k <= k + 1'b1;
    end
  end

  // Vertex memory write and registered read
  always_ff @(posedge clk) begin
    if (ld_accept && (32'(vertex_index) < MAX_VERTICES)) begin
      mem[vertex_index] <= {coord_x, coord_y};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
    end else begin
      rd_vld   <= rd_en;
      rd_first <= (k == '0);
    end
  end

  // Stage 1: differences against the previous vertex and the query point
  assign xi = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
  assign yi = rd_data[COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev_x  <= xi;
      prev_y  <= yi;
      ax      <= DW'(px) - DW'(xi);
      dy      <= DW'(prev_y) - DW'(yi);
      bx      <= DW'(prev_x) - DW'(xi);
      by      <= DW'(py) - DW'(yi);
      e_str   <= (yi > py) != (prev_y > py);
      e_dypos <= prev_y > yi;
    end
  end

  // Stage 2: cross products
  always_ff @(posedge clk) begin
    if (e_vld) begin
      p1      <= ax * dy;
      p2      <= bx * by;
      m_str   <= e_str;
      m_dypos <= e_dypos;
    end
  end

  // Stage 3: compare and toggle parity
  assign diff = FW'(p1) - FW'(p2);
  assign left = m_dypos ? diff[FW-1] : (!diff[FW-1] && (diff != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld  <= 1'b0;
      m_vld  <= 1'b0;
      parity <= 1'b0;
    end else begin
      e_vld <= rd_vld && !rd_first;
      m_vld <= e_vld;
      if (q_accept) begin
        parity <= 1'b0;
      end else if (m_vld && m_str && left) begin
        parity <= ~parity;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      res <= parity;
    end
  end

endmodule

@@ hw/rtl/pip_checker.sv @@
module pip_checker
  import pip_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic func,
  input logic out_valid,
  input logic out_ready,
  input logic inside_res
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inside_res))
    else $error("stalled result changed or dropped");

  // Drop ready after a query transaction
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_QUERY |=> !in_ready)
    else $error("block ready during a query");

  // A vertex load gives no result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_LOAD && !out_valid |=> !out_valid)
    else $error("result after a vertex load");

  // A result appears only at the end of a query
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a query in progress");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .func       (func),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .inside_res (inside_res)
);
